@@ src/alignment_block_line_parser_defines.svh @@
// Assertion macros for the alignment block line parser.
// Included by the top level; no other dependencies.
`ifndef ALIGNMENT_BLOCK_LINE_PARSER_DEFINES_SVH
`define ALIGNMENT_BLOCK_LINE_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ALP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ALP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ALP_ASSERT(lbl, prop, msg)
`define ALP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ src/alp_pkg.sv @@
// Types, codes and helper functions of the alignment block line parser.
// Used by alp_core, alp_outbuf and the top level.
package alp_pkg;

  typedef enum logic [11:0] {
    PH_LINE    = 12'b0000_0000_0001,
    PH_SECOND  = 12'b0000_0000_0010,
    PH_SKIP    = 12'b0000_0000_0100,
    PH_PRENAME = 12'b0000_0000_1000,
    PH_NAME    = 12'b0000_0001_0000,
    PH_NPRE    = 12'b0000_0010_0000,
    PH_NSIGN   = 12'b0000_0100_0000,
    PH_NDIG    = 12'b0000_1000_0000,
    PH_STRAND  = 12'b0001_0000_0000,
    PH_PREBASE = 12'b0010_0000_0000,
    PH_BASES   = 12'b0100_0000_0000,
    PH_TAIL    = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_BASE  = 3'd2,
    KIND_ROW   = 3'd3,
    KIND_END   = 3'd4,
    KIND_ERROR = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MALFORMED = 2'd0,
    ERR_OUTSIDE   = 2'd1,
    ERR_COLUMNS   = 2'd2,
    ERR_UNEXPECT  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_EOL  = 2'd1,
    FUNC_EOI  = 2'd2
  } func_e;

  localparam logic [1:0] FLD_START  = 2'd0;
  localparam logic [1:0] FLD_LENGTH = 2'd1;
  localparam logic [1:0] FLD_SOURCE = 2'd2;

  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_PLS = 8'h2b;
  localparam logic [7:0] CH_MIN = 8'h2d;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_I   = 8'h69;
  localparam logic [7:0] CH_E   = 8'h65;
  localparam logic [7:0] CH_Q   = 8'h71;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [63:0] MAG_CAP     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_CAP_D10 = MAG_CAP / 64'd10;

  localparam int unsigned TDATA_BITS = 256;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [63:0] row_start;
    logic [63:0] row_length;
    logic        row_strand;
    logic [63:0] source_length;
    logic [15:0] row_index;
    logic [31:0] column_total;
    err_e        error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_set_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_TAB) || (b == CH_SP);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_sign(input logic [7:0] b);
    return (b == CH_PLS) || (b == CH_MIN);
  endfunction

  function automatic logic is_eolch(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  // Multiply by ten and add the digit, saturating the magnitude.
  function automatic logic [63:0] acc_step(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] t;
    t = (acc << 3) + (acc << 1) + {60'd0, b[3:0]};
    if (acc > MAG_CAP_D10) return MAG_CAP;
    if (t > MAG_CAP) return MAG_CAP;
    return t;
  endfunction

  function automatic logic [63:0] sat_value(input logic [63:0] acc, input logic neg);
    if (neg) return (~acc) + 64'd1;
    if (acc >= MAG_CAP) return MAG_CAP - 64'd1;
    return acc;
  endfunction

endpackage

@@ src/alp_core.sv @@
// Parse state and per-item next-state logic of the alignment block line parser.
// Depends on alp_pkg.
module alp_core #(
  parameter int unsigned COLUMN_BITS = 32,
  parameter int unsigned ROW_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        byte_i,
  output alp_pkg::res_set_t res_o
);
  import alp_pkg::*;

  phase_e                 ph_q, ph_d;
  logic [1:0]             fld_q, fld_d;
  logic                   inside_q, inside_d;
  logic                   first_a_q, first_a_d;
  logic [63:0]            acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [63:0]            hstart_q, hstart_d;
  logic [63:0]            hlen_q, hlen_d;
  logic                   hstrand_q, hstrand_d;
  logic [63:0]            hsrc_q, hsrc_d;
  logic [COLUMN_BITS-1:0] base_q, base_d;
  logic [COLUMN_BITS-1:0] cols_q, cols_d;
  logic [ROW_BITS-1:0]    rows_q, rows_d;

  logic        p_valid, p_row, ev_npre1, ev_strand, ev_prebase, eoi_end;
  kind_e       p_kind;
  err_e        p_code;
  logic [7:0]  p_byte;
  logic [63:0] nval;
  logic [ROW_BITS+15:0]    rows_ext;
  logic [COLUMN_BITS+31:0] base_ext;
  res_t        prim, blk_end;

  always_comb begin
    ph_d = ph_q; fld_d = fld_q; inside_d = inside_q; first_a_d = first_a_q;
    acc_d = acc_q; neg_d = neg_q; hstart_d = hstart_q; hlen_d = hlen_q;
    hstrand_d = hstrand_q; hsrc_d = hsrc_q; base_d = base_q; cols_d = cols_q;
    rows_d = rows_q;
    p_valid = 1'b0; p_row = 1'b0; p_kind = KIND_START; p_code = ERR_MALFORMED;
    p_byte = 8'd0; ev_npre1 = 1'b0; ev_strand = 1'b0; ev_prebase = 1'b0;
    eoi_end = 1'b0;
    nval = sat_value(acc_q, neg_q);

    if (func_i == FUNC_BYTE) begin
      unique case (ph_q)
        PH_LINE: begin
          if (inside_q) begin
            if (is_eolch(byte_i)) begin
              p_valid = 1'b1; p_kind = KIND_END; inside_d = 1'b0; ph_d = PH_SKIP;
            end else if (byte_i == CH_S) begin
              first_a_d = 1'b0; ph_d = PH_SECOND;
            end else if (byte_i == CH_I || byte_i == CH_E || byte_i == CH_Q) begin
              ph_d = PH_SKIP;
            end else begin
              p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_UNEXPECT;
              ph_d = PH_SKIP; inside_d = 1'b0;
            end
          end else if (byte_i == CH_A || byte_i == CH_S) begin
            first_a_d = (byte_i == CH_A); ph_d = PH_SECOND;
          end else begin
            ph_d = PH_SKIP;
          end
        end
        PH_SECOND: begin
          ph_d = PH_SKIP;
          if (inside_q) begin
            if (is_ws(byte_i)) begin
              base_d = '0; hstart_d = '0; hlen_d = '0; hstrand_d = 1'b0; hsrc_d = '0;
              ph_d = PH_PRENAME;
            end else begin
              p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_UNEXPECT;
              inside_d = 1'b0;
            end
          end else if (first_a_q) begin
            if (is_ws(byte_i) || is_eolch(byte_i)) begin
              p_valid = 1'b1; p_kind = KIND_START; inside_d = 1'b1;
              rows_d = '0; cols_d = '0;
            end
          end else if (is_ws(byte_i)) begin
            p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_OUTSIDE; inside_d = 1'b0;
          end
        end
        PH_PRENAME, PH_NAME: begin
          if (is_ws(byte_i)) begin
            if (ph_q == PH_NAME) begin
              ph_d = PH_NPRE; fld_d = FLD_START;
            end
          end else begin
            p_valid = 1'b1; p_kind = KIND_NAME; p_byte = byte_i; ph_d = PH_NAME;
          end
        end
        PH_NPRE: begin
          if (is_digit(byte_i)) begin
            acc_d = {60'd0, byte_i[3:0]}; neg_d = 1'b0; ph_d = PH_NDIG;
          end else if (is_sign(byte_i)) begin
            acc_d = '0; neg_d = (byte_i == CH_MIN); ph_d = PH_NSIGN;
          end else if (!is_ws(byte_i)) begin
            // empty field reads as zero; byte goes on to the strand or bases
            acc_d = '0; neg_d = 1'b0;
            unique case (fld_q)
              FLD_START:  begin hstart_d = '0; hlen_d = '0; ev_strand = 1'b1; end
              FLD_LENGTH: begin hlen_d = '0; ev_strand = 1'b1; end
              default:    begin hsrc_d = '0; ev_prebase = 1'b1; end
            endcase
          end
        end
        PH_NSIGN: begin
          if (is_digit(byte_i)) begin
            acc_d = {60'd0, byte_i[3:0]}; ph_d = PH_NDIG;
          end else begin
            p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_MALFORMED;
            ph_d = PH_SKIP; inside_d = 1'b0;
          end
        end
        PH_NDIG: begin
          if (is_digit(byte_i)) begin
            acc_d = acc_step(acc_q, byte_i);
          end else begin
            unique case (fld_q)
              FLD_START:  begin hstart_d = nval; ev_npre1 = 1'b1; end
              FLD_LENGTH: begin hlen_d = nval; ev_strand = 1'b1; end
              default:    begin hsrc_d = nval; ev_prebase = 1'b1; end
            endcase
          end
        end
        PH_STRAND: ev_strand = 1'b1;
        PH_PREBASE, PH_BASES: begin
          // once bases have begun, tabs and spaces count as bases
          if (is_eolch(byte_i)) begin
            ph_d = PH_TAIL;
          end else if (!(ph_q == PH_PREBASE && is_ws(byte_i))) begin
            if (base_q != '1) base_d = base_q + 1'b1;
            p_valid = 1'b1; p_kind = KIND_BASE; p_byte = byte_i; ph_d = PH_BASES;
          end
        end
        default: ;
      endcase

      if (ev_npre1) begin
        if (is_ws(byte_i)) begin
          ph_d = PH_NPRE; fld_d = FLD_LENGTH;
        end else if (is_sign(byte_i)) begin
          acc_d = '0; neg_d = (byte_i == CH_MIN); ph_d = PH_NSIGN; fld_d = FLD_LENGTH;
        end else begin
          acc_d = '0; neg_d = 1'b0; hlen_d = '0; ev_strand = 1'b1;
        end
      end
      if (ev_strand) begin
        if (is_ws(byte_i)) begin
          ph_d = PH_STRAND;
        end else if (is_sign(byte_i)) begin
          hstrand_d = (byte_i == CH_PLS); ph_d = PH_NPRE; fld_d = FLD_SOURCE;
        end else begin
          p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_MALFORMED;
          ph_d = PH_SKIP; inside_d = 1'b0;
        end
      end
      if (ev_prebase) begin
        if (is_eolch(byte_i)) begin
          ph_d = PH_TAIL;
        end else if (is_ws(byte_i)) begin
          ph_d = PH_PREBASE;
        end else begin
          if (base_q != '1) base_d = base_q + 1'b1;
          p_valid = 1'b1; p_kind = KIND_BASE; p_byte = byte_i; ph_d = PH_BASES;
        end
      end
    end else begin
      // end of line or end of input
      unique case (ph_q)
        PH_LINE: begin
          if (inside_q) begin
            p_valid = 1'b1; p_kind = KIND_END; inside_d = 1'b0;
          end
        end
        PH_SECOND: begin
          if (inside_q) begin
            p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_UNEXPECT; inside_d = 1'b0;
          end else if (first_a_q) begin
            p_valid = 1'b1; p_kind = KIND_START; inside_d = 1'b1;
            rows_d = '0; cols_d = '0;
          end
        end
        PH_SKIP: ;
        PH_PRENAME, PH_NAME, PH_NPRE, PH_NSIGN, PH_NDIG, PH_STRAND,
        PH_PREBASE, PH_BASES, PH_TAIL: begin
          if ((ph_q == PH_NPRE || ph_q == PH_NDIG) && fld_q == FLD_SOURCE) begin
            hsrc_d = (ph_q == PH_NDIG) ? nval : 64'd0;
            ev_prebase = 1'b1;
          end else if (ph_q == PH_PREBASE || ph_q == PH_BASES || ph_q == PH_TAIL) begin
            ev_prebase = 1'b1;
          end else begin
            p_valid = 1'b1; p_kind = KIND_ERROR; p_code = ERR_MALFORMED; inside_d = 1'b0;
          end
          // row completion
          if (ev_prebase) begin
            if (rows_q != '1) rows_d = rows_q + 1'b1;
            p_valid = 1'b1; p_row = 1'b1;
            if (rows_q == '0) begin
              cols_d = base_q; p_kind = KIND_ROW;
            end else if (base_q != cols_q) begin
              p_kind = KIND_ERROR; p_code = ERR_COLUMNS; inside_d = 1'b0;
            end else begin
              p_kind = KIND_ROW;
            end
          end
        end
        default: ;
      endcase
      ph_d = PH_LINE;
      if (func_i != FUNC_EOL) begin
        eoi_end = inside_d;
        inside_d = 1'b0;
      end
    end
  end

  assign rows_ext = {16'd0, rows_d};
  assign base_ext = {32'd0, base_d};

  always_comb begin
    prim = '0;
    prim.kind = p_kind;
    prim.out_byte = p_byte;
    if (p_kind == KIND_ERROR) prim.error_code = p_code;
    if (p_row) begin
      prim.row_start     = hstart_d;
      prim.row_length    = hlen_d;
      prim.row_strand    = hstrand_d;
      prim.source_length = hsrc_d;
      prim.row_index     = rows_ext[15:0];
      prim.column_total  = base_ext[31:0];
    end
    blk_end = '0;
    blk_end.kind = KIND_END;
    blk_end.last = 1'b1;
    res_o = '0;
    if (p_valid && eoi_end) begin
      res_o.n = 2'd2; res_o.r0 = prim; res_o.r1 = blk_end;
    end else if (p_valid) begin
      prim.last = 1'b1;
      res_o.n = 2'd1; res_o.r0 = prim;
    end else if (eoi_end) begin
      res_o.n = 2'd1; res_o.r0 = blk_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_LINE; fld_q <= FLD_START; inside_q <= 1'b0; first_a_q <= 1'b0;
      acc_q <= '0; neg_q <= 1'b0; hstart_q <= '0; hlen_q <= '0; hstrand_q <= 1'b0;
      hsrc_q <= '0; base_q <= '0; cols_q <= '0; rows_q <= '0;
    end else if (fire_i) begin
      ph_q <= ph_d; fld_q <= fld_d; inside_q <= inside_d; first_a_q <= first_a_d;
      acc_q <= acc_d; neg_q <= neg_d; hstart_q <= hstart_d; hlen_q <= hlen_d;
      hstrand_q <= hstrand_d; hsrc_q <= hsrc_d; base_q <= base_d; cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

endmodule

@@ src/alp_outbuf.sv @@
// Two-entry result register of the alignment block line parser.
// Depends on alp_pkg.
module alp_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  alp_pkg::res_set_t set_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output alp_pkg::res_t     res_o
);
  import alp_pkg::*;

  logic [1:0] cnt_q;
  res_t       s0_q, s1_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = s0_q;
  // take a new item when empty or once the last waiting transfer leaves this cycle
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= set_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s0_q <= set_i.r0;
      s1_q <= set_i.r1;
    end else if (pop) begin
      s0_q <= s1_q;
    end
  end

endmodule

@@ src/alignment_block_line_parser.sv @@
// Top level of the alignment block line parser: input stream, parse core, result register.
// Depends on alp_pkg, alp_core, alp_outbuf and alignment_block_line_parser_defines.svh.
//
// Input stream: one item per transfer; tuser carries the item kind (text byte, end of
// line, end of input) and tdata the text byte. Output stream: result records; tuser
// carries the record kind, tdata the payload, tlast marks the final record of an item.
// Each item is parsed in the cycle it is taken; its records appear on the output in the
// cycle after. An item with no or one record leaves room for the next item, so while the
// receiver takes each record, throughput is one item per cycle; an item with two records
// (end of input closing a block) holds the input while the second record drains.
// The two-entry result register sets this rate.
// When the receiver stalls, records are held in the result register and the input
// deasserts tready unless it is empty or its last waiting record leaves in that cycle.
// Reset puts the parser at the start of a line outside any block, with all counters and
// held row fields cleared and no record pending.
`include "alignment_block_line_parser_defines.svh"
module alignment_block_line_parser #(
  parameter int unsigned COLUMN_BITS = 32,
  parameter int unsigned ROW_BITS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]   s_axis_tuser_i,  // [1:0] func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] out_byte, [71:8] row_start, [135:72] row_length, [136] row_strand,
  // [200:137] source_length, [216:201] row_index, [248:217] column_total,
  // [250:249] error_code, [255:251] zero
  output logic [255:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,  // [2:0] kind
  output logic         m_axis_tlast_o
);
  import alp_pkg::*;

  logic     fire;
  res_set_t set;
  res_t     res;

  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  alp_core #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .func_i(s_axis_tuser_i),
    .byte_i(s_axis_tdata_i),
    .res_o (set)
  );

  alp_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .set_i  (set),
    .room_o (s_axis_tready_o),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .res_o  (res)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;
  assign m_axis_tdata_o = {5'd0, res.error_code, res.column_total, res.row_index,
                           res.source_length, res.row_strand, res.row_length,
                           res.row_start, res.out_byte};

  `ALP_ASSERT(a_kind_range, m_axis_tvalid_o |-> (m_axis_tuser_o <= KIND_ERROR), "bad kind")
  `ALP_ASSERT(a_code_on_err, (m_axis_tvalid_o && m_axis_tuser_o != KIND_ERROR) |-> (m_axis_tdata_o[250:249] == 2'd0), "error code outside error")
  `ALP_ASSERT(a_row_fields, (m_axis_tvalid_o && m_axis_tuser_o != KIND_ROW && m_axis_tuser_o != KIND_ERROR) |-> (m_axis_tdata_o[248:201] == 48'd0), "row fields outside row")
  `ALP_ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")

endmodule
